### rtl/scf_pkg.sv
// scf_pkg: shared types, scancode constants and the fixed key maps
// used by the front decoder, the command queue and the ring back end
// no dependencies
package scf_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MAP_ENTRIES    = 89;
  localparam int MAP_AW         = $clog2(MAP_ENTRIES);
  localparam int CMDQ_DEPTH     = 2;
  localparam int OUT_DEPTH      = 4;
  localparam int FILL_W         = 8;

  localparam logic [7:0] SC_LSHIFT  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_CAPS    = 8'h3a;
  localparam logic [7:0] SC_PGUP    = 8'h49;
  localparam logic [7:0] SC_PGDN    = 8'h51;
  localparam logic [7:0] SC_PREFIX  = 8'he0;
  localparam logic [7:0] SC_RELEASE = 8'h80;

  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [1:0] SCROLL_NONE = 2'd0;
  localparam logic [1:0] SCROLL_UP   = 2'd1;
  localparam logic [1:0] SCROLL_DOWN = 2'd2;

  // zero marks an unmapped key, no mapped key yields code zero
  localparam logic [7:0] NORMAL_MAP [MAP_ENTRIES] = '{
    8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd48,  8'd39,  8'd141, 8'd8,   8'd9,   8'd113, 8'd119, 8'd101, 8'd114,
    8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd138, 8'd43,  8'd13,  8'd0,
    8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd149,
    8'd133, 8'd92,  8'd0,   8'd151, 8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110,
    8'd109, 8'd44,  8'd46,  8'd45,  8'd0,   8'd42,  8'd0,   8'd32,  8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd55,  8'd56,  8'd57,  8'd45,  8'd52,  8'd53,  8'd54,  8'd43,  8'd49,
    8'd50,  8'd51,  8'd48,  8'd46,  8'd0,   8'd0,   8'd60,  8'd0,   8'd0
  };

  localparam logic [7:0] SHIFTED_MAP [MAP_ENTRIES] = '{
    8'd0,   8'd0,   8'd33,  8'd34,  8'd156, 8'd36,  8'd37,  8'd38,  8'd47,  8'd40,
    8'd41,  8'd61,  8'd63,  8'd94,  8'd0,   8'd0,   8'd81,  8'd87,  8'd69,  8'd82,
    8'd84,  8'd89,  8'd85,  8'd73,  8'd79,  8'd80,  8'd130, 8'd42,  8'd0,   8'd0,
    8'd65,  8'd83,  8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd128,
    8'd167, 8'd124, 8'd0,   8'd0,   8'd90,  8'd88,  8'd67,  8'd86,  8'd66,  8'd78,
    8'd77,  8'd59,  8'd58,  8'd95,  8'd0,   8'd0,   8'd0,   8'd32,  8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd62,  8'd0,   8'd0
  };

  // command handed from the front decoder to the ring back end
  typedef struct packed {
    logic       is_read;
    logic       is_push;
    logic [7:0] ch;
    logic       caps;
    logic       leds;
    logic [1:0] scroll;
    logic       unknown;
  } scf_cmd_t;

  // one result as seen on the output queue
  typedef struct packed {
    logic              char_valid;
    logic [7:0]        char_code;
    logic              caps_on;
    logic              leds_changed;
    logic [1:0]        scroll;
    logic              unknown_code;
    logic [FILL_W-1:0] fill_level;
  } scf_res_t;

  function automatic logic [7:0] map_lookup(input logic shifted, input logic [7:0] sc);
    logic [MAP_AW-1:0] idx;
    logic [7:0]        res;
    idx = sc[MAP_AW-1:0];
    res = 8'd0;
    if (sc < 8'(MAP_ENTRIES)) begin
      res = shifted ? SHIFTED_MAP[idx] : NORMAL_MAP[idx];
    end
    return res;
  endfunction

endpackage

### rtl/scf_front.sv
// scf_front: accepts items, tracks shift and caps lock, looks keys up
// and hands one command per item to the command queue
// depends on scf_pkg
module scf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_kind,
  input  logic [7:0]        in_scancode,
  input  logic              accept,
  output scf_pkg::scf_cmd_t cmd
);

  logic       shift_r, shift_nxt;
  logic       caps_r, caps_nxt;
  logic [7:0] entry;
  logic [7:0] ch;

  always_comb begin
    cmd       = '0;
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    entry     = scf_pkg::map_lookup(shift_r, in_scancode);
    ch        = entry;
    if (in_kind) begin
      cmd.is_read = 1'b1;
    end else if (in_scancode == scf_pkg::SC_LSHIFT || in_scancode == scf_pkg::SC_RSHIFT) begin
      shift_nxt = 1'b1;
    end else if (in_scancode == scf_pkg::SC_CAPS) begin
      caps_nxt = ~caps_r;
      cmd.leds = 1'b1;
    end else if (in_scancode == scf_pkg::SC_PGUP) begin
      cmd.scroll = scf_pkg::SCROLL_UP;
    end else if (in_scancode == scf_pkg::SC_PGDN) begin
      cmd.scroll = scf_pkg::SCROLL_DOWN;
    end else if ((in_scancode & scf_pkg::SC_RELEASE) == 8'd0) begin
      if (entry != 8'd0) begin
        if (caps_r && entry >= scf_pkg::CHAR_LOWER_A && entry <= scf_pkg::CHAR_LOWER_Z) begin
          ch = entry - scf_pkg::CASE_OFFSET;
        end
        cmd.is_push = 1'b1;
        cmd.ch      = ch;
      end else begin
        cmd.unknown = 1'b1;
      end
    end else if (in_scancode != scf_pkg::SC_PREFIX) begin
      if (in_scancode == (scf_pkg::SC_LSHIFT | scf_pkg::SC_RELEASE) ||
          in_scancode == (scf_pkg::SC_RSHIFT | scf_pkg::SC_RELEASE)) begin
        shift_nxt = 1'b0;
      end
    end
    cmd.caps = caps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule

### rtl/scf_cmdq.sv
// scf_cmdq: short command queue between the front decoder and the back end
// depends on scf_pkg
module scf_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  scf_pkg::scf_cmd_t wr_cmd,
  output logic              full,
  input  logic              rd_en,
  output scf_pkg::scf_cmd_t rd_cmd,
  output logic              rd_valid
);

  localparam int AW = $clog2(scf_pkg::CMDQ_DEPTH);
  localparam int CW = AW + 1;

  scf_pkg::scf_cmd_t slot_r [scf_pkg::CMDQ_DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(scf_pkg::CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == AW'(scf_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == AW'(scf_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

### rtl/scf_back.sv
// scf_back: character ring memory, one result stage and the output queue
// depends on scf_pkg
module scf_back #(
  parameter int RING_DEPTH = scf_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scf_pkg::scf_cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  logic              pop,
  output logic              empty,
  output scf_pkg::scf_res_t res
);

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int OUT_AW  = $clog2(scf_pkg::OUT_DEPTH);
  localparam int OUT_CW  = OUT_AW + 1;

  // ring state
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [7:0]         ring_rdata_r;
  logic [RING_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [RING_AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [RING_AW-1:0] cnt_r, cnt_nxt;
  logic               do_read, do_write;
  logic [31:0]        cnt_wide;

  // result stage, char code follows from the registered memory data
  logic                      s2_valid_r;
  logic                      s2_cv_r;
  logic                      s2_caps_r;
  logic                      s2_leds_r;
  logic [1:0]                s2_scroll_r;
  logic                      s2_unknown_r;
  logic [scf_pkg::FILL_W-1:0] s2_fill_r, fill_nxt;
  scf_pkg::scf_res_t         s2_res;

  // output queue
  scf_pkg::scf_res_t  oq_r [scf_pkg::OUT_DEPTH];
  logic [OUT_AW-1:0]  oq_wptr_r;
  logic [OUT_AW-1:0]  oq_rptr_r;
  logic [OUT_CW-1:0]  oq_cnt_r;
  logic               oq_pop;
  logic [OUT_CW-1:0]  in_flight;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
    return (i == RING_AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // issue only with room reserved for this command and the one in the result stage
  assign in_flight = oq_cnt_r + OUT_CW'(s2_valid_r);
  assign cmd_take  = cmd_valid && (in_flight < OUT_CW'(scf_pkg::OUT_DEPTH));
  assign do_read   = cmd_take && cmd.is_read && (cnt_r != '0);
  assign do_write  = cmd_take && cmd.is_push;

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    cnt_nxt    = cnt_r;
    if (do_read) begin
      rd_idx_nxt = ring_next(rd_idx_r);
      cnt_nxt    = cnt_r - 1'b1;
    end else if (do_write) begin
      wr_idx_nxt = ring_next(wr_idx_r);
      // full ring drops the oldest character
      if (cnt_r == RING_AW'(RING_DEPTH - 1)) begin
        rd_idx_nxt = ring_next(rd_idx_r);
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    cnt_wide = 32'(cnt_nxt);
    fill_nxt = (cnt_wide > 32'd255) ? 8'hff : cnt_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      cnt_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      rd_idx_r   <= rd_idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      cnt_r      <= cnt_nxt;
      s2_valid_r <= cmd_take;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      ring_mem[wr_idx_r] <= cmd.ch;
    end
    if (do_read) begin
      ring_rdata_r <= ring_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s2_cv_r      <= do_read;
      s2_caps_r    <= cmd.caps;
      s2_leds_r    <= cmd.leds;
      s2_scroll_r  <= cmd.scroll;
      s2_unknown_r <= cmd.unknown;
      s2_fill_r    <= fill_nxt;
    end
  end

  always_comb begin
    s2_res.char_valid   = s2_cv_r;
    s2_res.char_code    = s2_cv_r ? ring_rdata_r : 8'd0;
    s2_res.caps_on      = s2_caps_r;
    s2_res.leds_changed = s2_leds_r;
    s2_res.scroll       = s2_scroll_r;
    s2_res.unknown_code = s2_unknown_r;
    s2_res.fill_level   = s2_fill_r;
  end

  assign empty  = (oq_cnt_r == '0);
  assign oq_pop = pop && !empty;
  assign res    = oq_r[oq_rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (s2_valid_r) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
      if (s2_valid_r && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (!s2_valid_r && oq_pop) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      oq_r[oq_wptr_r] <= s2_res;
    end
  end

endmodule

### rtl/scancode_to_char_fifo.sv
// scancode_to_char_fifo: set-1 scancode decoder with a character ring buffer
// depends on scf_pkg, scf_front, scf_cmdq, scf_back
//
//   channel  handshake      payload
//   input    push / full    in_kind, in_scancode
//   result   pop / empty    out_char_valid, out_char_code, out_caps_on,
//                           out_leds_changed, out_scroll, out_unknown_code,
//                           out_fill_level
//
// one item per cycle while results are popped, every item gives exactly one result
// a result passes the command queue and the registered ring memory access in the
// result stage, then it waits in the output queue
// the ring has one write and one registered read port; up to one command a cycle
// synchronous active-low reset clears the indices, the modes and both queues
// a stalled output fills the output queue, then the command queue, then full rises
module scancode_to_char_fifo #(
  parameter int RING_DEPTH = scf_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_kind,
  input  logic [7:0]                 in_scancode,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_char_valid,
  output logic [7:0]                 out_char_code,
  output logic                       out_caps_on,
  output logic                       out_leds_changed,
  output logic [1:0]                 out_scroll,
  output logic                       out_unknown_code,
  output logic [scf_pkg::FILL_W-1:0] out_fill_level
);

  logic              accept;
  scf_pkg::scf_cmd_t front_cmd;
  scf_pkg::scf_cmd_t q_cmd;
  logic              q_valid;
  logic              q_take;
  scf_pkg::scf_res_t res;

  assign accept = push && !full;

  scf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_kind),
    .in_scancode (in_scancode),
    .accept      (accept),
    .cmd         (front_cmd)
  );

  scf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid)
  );

  scf_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_char_valid   = res.char_valid;
  assign out_char_code    = res.char_code;
  assign out_caps_on      = res.caps_on;
  assign out_leds_changed = res.leds_changed;
  assign out_scroll       = res.scroll;
  assign out_unknown_code = res.unknown_code;
  assign out_fill_level   = res.fill_level;

  // queues come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  // no character code without a popped character
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_char_valid) |-> out_char_code == 8'd0)
    else $error("char code set without a popped character");

  // a caps lock step carries no other event
  a_leds_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_leds_changed) |->
      (out_scroll == scf_pkg::SCROLL_NONE && !out_unknown_code && !out_char_valid))
    else $error("caps lock result carries another event");

  // the command queue is only drained when it holds something
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
    else $error("command taken from an empty queue");

endmodule

### tb/sv/tb_scancode_to_char_fifo.sv
`timescale 1ns / 1ps
// tb_scancode_to_char_fifo: self-checking bench for the scancode decoder and its character ring
// directed table then random key and read traffic, checked by typed rows or a local decoder
// depends on scf_pkg and scancode_to_char_fifo
module tb_scancode_to_char_fifo;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int KEY_SLOTS  = 89;
  localparam int RING_HOLD  = scf_pkg::RING_DEPTH_DEF - 1;
  localparam int N_DIRECTED = 26;
  localparam int END_SETTLE = 10;

  localparam logic [7:0] SC_LSHIFT_UP = scf_pkg::SC_LSHIFT | scf_pkg::SC_RELEASE;
  localparam logic [7:0] SC_RSHIFT_UP = scf_pkg::SC_RSHIFT | scf_pkg::SC_RELEASE;

  localparam logic [1:0] SCR_NONE = scf_pkg::SCROLL_NONE;
  localparam logic [1:0] SCR_UP   = scf_pkg::SCROLL_UP;
  localparam logic [1:0] SCR_DOWN = scf_pkg::SCROLL_DOWN;

  localparam logic [7:0] SPECIAL_CODES [8] = '{
    scf_pkg::SC_LSHIFT, scf_pkg::SC_RSHIFT, scf_pkg::SC_CAPS, scf_pkg::SC_PGUP,
    scf_pkg::SC_PGDN, scf_pkg::SC_PREFIX, SC_LSHIFT_UP, SC_RSHIFT_UP
  };

  // zero means no character on that key
  localparam logic [7:0] PLAIN_KEYS [KEY_SLOTS] = '{
    0,   27,  49,  50,  51,  52,  53,  54,  55,  56,  57,  48,
    39,  141, 8,   9,   113, 119, 101, 114, 116, 121, 117, 105,
    111, 112, 138, 43,  13,  0,   97,  115, 100, 102, 103, 104,
    106, 107, 108, 149, 133, 92,  0,   151, 122, 120, 99,  118,
    98,  110, 109, 44,  46,  45,  0,   42,  0,   32,  0,   0,
    0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   55,
    56,  57,  45,  52,  53,  54,  43,  49,  50,  51,  48,  46,
    0,   0,   60,  0,   0
  };

  localparam logic [7:0] SHIFTED_KEYS [KEY_SLOTS] = '{
    0,   0,   33,  34,  156, 36,  37,  38,  47,  40,  41,  61,
    63,  94,  0,   0,   81,  87,  69,  82,  84,  89,  85,  73,
    79,  80,  130, 42,  0,   0,   65,  83,  68,  70,  71,  72,
    74,  75,  76,  128, 167, 124, 0,   0,   90,  88,  67,  86,
    66,  78,  77,  59,  58,  95,  0,   0,   0,   32,  0,   0,
    0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,
    0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,
    0,   0,   62,  0,   0
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    bit         typed;
    logic       valid;
    logic [7:0] ch;
    logic       caps;
    logic       leds;
    logic [1:0] scroll;
    logic       unk;
    logic [7:0] fill;
  } key_row_t;

  // typed rows all come before the first character is stored
  localparam key_row_t DIRECTED [N_DIRECTED] = '{
    '{KIND_READ, 8'h00,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h00,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b1, 8'd0},
    '{KIND_KEY,  8'h59,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b1, 8'd0},
    '{KIND_KEY,  8'h7f,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b1, 8'd0},
    '{KIND_KEY,  8'h54,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b1, 8'd0},
    '{KIND_KEY,  8'hff,               1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_RELEASE, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_PREFIX,  1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_PGUP,    1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_UP,   1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_PGDN,    1'b1, 1'b0, 8'd0, 1'b0, 1'b0, SCR_DOWN, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_CAPS,    1'b1, 1'b0, 8'd0, 1'b1, 1'b1, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h1e,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h02,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_CAPS,    1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h2c,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_LSHIFT,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h01,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h10,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  SC_LSHIFT_UP,        1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  scf_pkg::SC_RSHIFT,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h56,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  SC_RSHIFT_UP,        1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_KEY,  8'h56,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_READ, 8'hff,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_READ, 8'h00,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0},
    '{KIND_READ, 8'h5a,               1'b0, 1'b0, 8'd0, 1'b0, 1'b0, SCR_NONE, 1'b0, 8'd0}
  };

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       push        = 1'b0;
  logic                       in_kind     = 1'b0;
  logic [7:0]                 in_scancode = 8'd0;
  logic                       pop         = 1'b0;
  logic                       full;
  logic                       empty;
  logic                       out_char_valid;
  logic [7:0]                 out_char_code;
  logic                       out_caps_on;
  logic                       out_leds_changed;
  logic [1:0]                 out_scroll;
  logic                       out_unknown_code;
  logic [scf_pkg::FILL_W-1:0] out_fill_level;

  // decoder state as the bench sees it
  logic       shift_held = 1'b0;
  logic       caps_held  = 1'b0;
  logic [7:0] held_chars [$];
  int         dropped_chars = 0;

  scf_pkg::scf_res_t pending_results [$];
  int                mismatches = 0;
  bit                steady     = 1'b0;

  scancode_to_char_fifo dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_scancode      (in_scancode),
    .empty            (empty),
    .pop              (pop),
    .out_char_valid   (out_char_valid),
    .out_char_code    (out_char_code),
    .out_caps_on      (out_caps_on),
    .out_leds_changed (out_leds_changed),
    .out_scroll       (out_scroll),
    .out_unknown_code (out_unknown_code),
    .out_fill_level   (out_fill_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic scf_pkg::scf_res_t decode_key(input logic kind, input logic [7:0] sc);
    scf_pkg::scf_res_t r;
    logic [7:0]        ch;
    int                n;
    r = '0;
    if (kind == KIND_READ) begin
      if (held_chars.size() > 0) begin
        r.char_valid = 1'b1;
        r.char_code  = held_chars.pop_front();
      end
    end else if (sc == scf_pkg::SC_LSHIFT || sc == scf_pkg::SC_RSHIFT) begin
      shift_held = 1'b1;
    end else if (sc == scf_pkg::SC_CAPS) begin
      caps_held      = !caps_held;
      r.leds_changed = 1'b1;
    end else if (sc == scf_pkg::SC_PGUP) begin
      r.scroll = SCR_UP;
    end else if (sc == scf_pkg::SC_PGDN) begin
      r.scroll = SCR_DOWN;
    end else if (sc < scf_pkg::SC_RELEASE) begin
      ch = 8'd0;
      if (sc < KEY_SLOTS) begin
        ch = shift_held ? SHIFTED_KEYS[sc] : PLAIN_KEYS[sc];
      end
      if (ch == 8'd0) begin
        r.unknown_code = 1'b1;
      end else begin
        if (caps_held && ch >= scf_pkg::CHAR_LOWER_A && ch <= scf_pkg::CHAR_LOWER_Z) begin
          ch = ch - scf_pkg::CASE_OFFSET;
        end
        // ring full: oldest character goes first
        if (held_chars.size() == RING_HOLD) begin
          void'(held_chars.pop_front());
          dropped_chars++;
        end
        held_chars.push_back(ch);
      end
    end else if (sc == SC_LSHIFT_UP || sc == SC_RSHIFT_UP) begin
      shift_held = 1'b0;
    end
    n            = held_chars.size();
    r.caps_on    = caps_held;
    r.fill_level = scf_pkg::FILL_W'(n > 255 ? 255 : n);
    return r;
  endfunction

  function automatic logic [7:0] pick_scancode(input int key_pct);
    int r;
    if ($urandom_range(0, 99) < key_pct) begin
      return 8'($urandom_range(0, KEY_SLOTS - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return SPECIAL_CODES[$urandom_range(0, 7)];
    end
    if (r < 70) begin
      return 8'($urandom_range(128, 255));
    end
    return 8'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // one transfer in, expectation stored once the block has taken it
  task automatic send_key(input logic kind, input logic [7:0] sc, input bit typed,
                          input scf_pkg::scf_res_t want);
    int                gap;
    scf_pkg::scf_res_t predicted;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    in_kind     <= kind;
    in_scancode <= sc;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = decode_key(kind, sc);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random(input int read_pct, input int key_pct);
    logic kind;
    kind = ($urandom_range(0, 99) < read_pct) ? KIND_READ : KIND_KEY;
    send_key(kind, pick_scancode(key_pct), 1'b0, '0);
  endtask

  task automatic drain_pending();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    scf_pkg::scf_res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no transfer pending");
      return;
    end
    want = pending_results.pop_front();
    if (out_char_valid !== want.char_valid)
      report_mismatch($sformatf("char_valid got %0b want %0b", out_char_valid, want.char_valid));
    if (out_char_code !== want.char_code)
      report_mismatch($sformatf("char_code got %0d want %0d", out_char_code, want.char_code));
    if (out_caps_on !== want.caps_on)
      report_mismatch($sformatf("caps_on got %0b want %0b", out_caps_on, want.caps_on));
    if (out_leds_changed !== want.leds_changed)
      report_mismatch($sformatf("leds_changed got %0b want %0b", out_leds_changed,
                                want.leds_changed));
    if (out_scroll !== want.scroll)
      report_mismatch($sformatf("scroll got %0d want %0d", out_scroll, want.scroll));
    if (out_unknown_code !== want.unknown_code)
      report_mismatch($sformatf("unknown_code got %0b want %0b", out_unknown_code,
                                want.unknown_code));
    if (out_fill_level !== want.fill_level)
      report_mismatch($sformatf("fill_level got %0d want %0d", out_fill_level, want.fill_level));
  endtask

  initial begin : result_side
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result();
    end
  end

  initial begin : stimulus
    int                i;
    key_row_t          row;
    scf_pkg::scf_res_t want;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      row                = DIRECTED[i];
      want               = '0;
      want.char_valid    = row.valid;
      want.char_code     = row.ch;
      want.caps_on       = row.caps;
      want.leds_changed  = row.leds;
      want.scroll        = row.scroll;
      want.unknown_code  = row.unk;
      want.fill_level    = row.fill;
      send_key(row.kind, row.code, row.typed, want);
    end
    drain_pending();

    // back to back on both sides, then mixed traffic near empty
    steady = 1'b1;
    for (i = 0; i < 40; i++) send_random(40, 55);
    steady = 1'b0;
    for (i = 0; i < 100; i++) send_random(40, 55);

    // hold off until everything has come back
    drain_pending();

    // mostly mapped keys and no reads, well past the point where the ring wraps
    while (dropped_chars < 20) send_random(0, 97);

    steady = 1'b1;
    for (i = 0; i < 40; i++) send_random(90, 55);
    steady = 1'b0;
    for (i = 0; i < 130; i++) send_random(90, 55);

    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### scancode_to_char_fifo.f
rtl/scf_pkg.sv
rtl/scf_front.sv
rtl/scf_cmdq.sv
rtl/scf_back.sv
rtl/scancode_to_char_fifo.sv
tb/sv/tb_scancode_to_char_fifo.sv
